[hdl/ffsca_pkg.sv]
package ffsca_pkg;

	typedef logic [2:0] status_t;

	localparam status_t STAT_OK        = 3'd0;
	localparam status_t STAT_ZERO_SIZE = 3'd1;
	localparam status_t STAT_TOO_LARGE = 3'd2;
	localparam status_t STAT_FULL      = 3'd3;
	localparam status_t STAT_NO_SLOT   = 3'd4;
	localparam status_t STAT_UNKNOWN   = 3'd5;

	typedef logic [1:0] cfg_index_t;

	localparam cfg_index_t CFG_HEADER_BYTES    = 2'd0;
	localparam cfg_index_t CFG_SPLIT_MINIMUM   = 2'd1;
	localparam cfg_index_t CFG_LARGE_THRESHOLD = 2'd2;

	localparam logic [6:0]  HEADER_RESET    = 7'd32;
	localparam logic [11:0] SPLIT_RESET     = 12'd128;
	localparam logic [20:0] THRESHOLD_RESET = 21'd131072;

	localparam logic [33:0] ARENA_BYTES = 34'd1048576;

	localparam logic OP_ALLOCATE = 1'b0;
	localparam logic OP_RELEASE  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WALK,
		ST_FIT,
		ST_LINK,
		ST_TAIL,
		ST_APPEND_LINK,
		ST_REL_NEXT,
		ST_REL_PREV,
		ST_DONE
	} state_t;

endpackage

[hdl/first_fit_split_coalesce_allocator_core.sv]
// First-fit heap allocator with splitting and coalescing. The block list lives in on-chip
// memories indexed by slot, walked one list entry per cycle through the single read port of
// the slot memories; the list holds at most MAX_BLOCKS entries. After the walk a fitting
// block is split when room allows, or at the list end the free tail block is enlarged or a
// new block is appended; a release of a live block merges it with its successor and then its
// predecessor where those are free. Rejected sizes and null releases skip the walk. One
// item is worked on at a time; s_tready is high only between items, and a finished result is
// held in an output register so that the next item may be taken while it waits.
module first_fit_split_coalesce_allocator_core #(
	parameter int MAX_BLOCKS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // request_size [19:0], payload_address [39:20]
	input  logic [0:0]  s_tuser,   // operation [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// status [2:0], granted_address [22:3], free_blocks [29:23], free_bytes [50:30],
	// total_blocks [57:51], total_bytes [78:58], zero [79]
	output logic [79:0] m_tdata,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [20:0] cfg_data
);

	localparam int SLOT_W = $clog2(MAX_BLOCKS);
	localparam int IDX_W = $clog2(MAX_BLOCKS + 1);
	localparam logic [IDX_W-1:0] NIL = IDX_W'(MAX_BLOCKS);
	localparam logic [33:0] ARENA_LIM = ffsca_pkg::ARENA_BYTES;

	ffsca_pkg::state_t state_q, state_d;

	logic [6:0]  hdr_q;
	logic [11:0] split_q;
	logic [20:0] thr_q;

	logic [19:0] start_mem [MAX_BLOCKS];
	logic [20:0] len_mem [MAX_BLOCKS];
	logic        free_mem [MAX_BLOCKS];
	logic [IDX_W-1:0] succ_mem [MAX_BLOCKS];
	logic [IDX_W-1:0] pred_mem [MAX_BLOCKS];

	logic [19:0] rd_start_q;
	logic [20:0] rd_len_q;
	logic        rd_free_q;
	logic [IDX_W-1:0] rd_succ_q, rd_pred_q;
	logic        rd_en;
	logic [IDX_W-1:0] rd_idx;

	logic start_we, len_we, free_we, succ_we, pred_we;
	logic [IDX_W-1:0] start_wa, len_wa, free_wa, succ_wa, pred_wa;
	logic [19:0] start_wd;
	logic [20:0] len_wd;
	logic        free_wd;
	logic [IDX_W-1:0] succ_wd, pred_wd;

	logic [MAX_BLOCKS-1:0] in_use_q;
	logic [IDX_W-1:0] head_q, tail_q;
	logic [20:0] arena_q;
	logic [6:0]  fblk_q, blk_q;
	logic [20:0] fbyte_q, byte_q;

	logic        op_q;
	logic [19:0] size_q, addr_q;
	logic [IDX_W-1:0] cur_q, slot_q, cur_succ_q, cur_pred_q;
	logic [20:0] cur_len_q;
	ffsca_pkg::status_t status_q;
	logic [19:0] grant_q;

	logic        m_tvalid_q;
	logic [79:0] m_tdata_q;

	logic [IDX_W-1:0] free_slot;
	logic        accept, fits, split_ok, tail_grow, grow_over, app_over, out_free;
	logic        next_merge, prev_merge;
	logic [21:0] fit_need;
	logic [19:0] split_start;
	logic [20:0] split_len, grow_need, merge_next_len, merge_prev_len;

	always_comb begin
		free_slot = NIL;
		for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_slot = IDX_W'(i);
			end
		end
	end

	assign accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign fits = rd_free_q && (rd_len_q >= {1'b0, size_q});
	assign fit_need = {2'b0, size_q} + 22'(split_q) + 22'(hdr_q);
	assign split_ok = ({1'b0, rd_len_q} >= fit_need) && (free_slot != NIL);
	assign split_start = rd_start_q + size_q + 20'(hdr_q);
	assign split_len = rd_len_q - {1'b0, size_q} - 21'(hdr_q);
	assign tail_grow = (tail_q != NIL) && rd_free_q;
	assign grow_need = {1'b0, size_q} - rd_len_q;
	assign grow_over = (34'(arena_q) + 34'(grow_need)) > ARENA_LIM;
	assign app_over = (34'(arena_q) + 34'(hdr_q) + 34'(size_q)) > ARENA_LIM;
	assign next_merge = (cur_succ_q != NIL) && rd_free_q;
	assign prev_merge = (cur_pred_q != NIL) && rd_free_q;
	assign merge_next_len = cur_len_q + 21'(hdr_q) + rd_len_q;
	assign merge_prev_len = rd_len_q + 21'(hdr_q) + cur_len_q;

	assign s_tready = (state_q == ffsca_pkg::ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ffsca_pkg::ST_IDLE: begin
				if (accept) begin
					if (s_tuser[0] == ffsca_pkg::OP_ALLOCATE) begin
						if (s_tdata[19:0] == 20'd0 || {1'b0, s_tdata[19:0]} >= thr_q) begin
							state_d = ffsca_pkg::ST_DONE;
						end else begin
							state_d = ffsca_pkg::ST_WALK;
						end
					end else if (s_tdata[39:20] == 20'd0) begin
						state_d = ffsca_pkg::ST_DONE;
					end else begin
						state_d = ffsca_pkg::ST_WALK;
					end
				end
			end
			ffsca_pkg::ST_WALK: begin
				if (op_q == ffsca_pkg::OP_ALLOCATE) begin
					if (cur_q == NIL) begin
						state_d = ffsca_pkg::ST_TAIL;
					end else if (fits) begin
						state_d = ffsca_pkg::ST_FIT;
					end
				end else if (cur_q == NIL) begin
					state_d = ffsca_pkg::ST_DONE;
				end else if (rd_start_q == addr_q) begin
					state_d = rd_free_q ? ffsca_pkg::ST_DONE : ffsca_pkg::ST_REL_NEXT;
				end
			end
			ffsca_pkg::ST_FIT: begin
				state_d = split_ok ? ffsca_pkg::ST_LINK : ffsca_pkg::ST_DONE;
			end
			ffsca_pkg::ST_LINK: state_d = ffsca_pkg::ST_DONE;
			ffsca_pkg::ST_TAIL: begin
				if (!tail_grow && !app_over && free_slot != NIL && tail_q != NIL) begin
					state_d = ffsca_pkg::ST_APPEND_LINK;
				end else begin
					state_d = ffsca_pkg::ST_DONE;
				end
			end
			ffsca_pkg::ST_APPEND_LINK: state_d = ffsca_pkg::ST_DONE;
			ffsca_pkg::ST_REL_NEXT: state_d = ffsca_pkg::ST_REL_PREV;
			ffsca_pkg::ST_REL_PREV: state_d = ffsca_pkg::ST_DONE;
			ffsca_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = ffsca_pkg::ST_IDLE;
				end
			end
			default: state_d = ffsca_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		rd_en = 1'b0;
		rd_idx = cur_q;
		start_we = 1'b0;
		start_wa = slot_q;
		start_wd = split_start;
		len_we = 1'b0;
		len_wa = slot_q;
		len_wd = split_len;
		free_we = 1'b0;
		free_wa = cur_q;
		free_wd = 1'b0;
		succ_we = 1'b0;
		succ_wa = slot_q;
		succ_wd = rd_succ_q;
		pred_we = 1'b0;
		pred_wa = slot_q;
		pred_wd = cur_q;
		unique case (state_q)
			ffsca_pkg::ST_IDLE: begin
				rd_en = accept;
				rd_idx = head_q;
			end
			ffsca_pkg::ST_WALK: begin
				if (op_q == ffsca_pkg::OP_ALLOCATE) begin
					if (cur_q == NIL) begin
						rd_en = 1'b1;
						rd_idx = tail_q;
					end else if (!fits) begin
						rd_en = 1'b1;
						rd_idx = rd_succ_q;
					end
				end else if (cur_q != NIL) begin
					rd_en = 1'b1;
					rd_idx = rd_succ_q;
					if (rd_start_q == addr_q && !rd_free_q) begin
						free_we = 1'b1;
						free_wd = 1'b1;
					end
				end
			end
			ffsca_pkg::ST_FIT: begin
				if (split_ok) begin
					start_we = 1'b1;
					start_wa = free_slot;
					len_we = 1'b1;
					len_wa = free_slot;
					free_we = 1'b1;
					free_wa = free_slot;
					free_wd = 1'b1;
					succ_we = 1'b1;
					succ_wa = free_slot;
					pred_we = 1'b1;
					pred_wa = free_slot;
				end else begin
					free_we = 1'b1;
				end
			end
			ffsca_pkg::ST_LINK: begin
				len_we = 1'b1;
				len_wa = cur_q;
				len_wd = {1'b0, size_q};
				free_we = 1'b1;
				succ_we = 1'b1;
				succ_wa = cur_q;
				succ_wd = slot_q;
				pred_we = (rd_succ_q != NIL);
				pred_wa = rd_succ_q;
				pred_wd = slot_q;
			end
			ffsca_pkg::ST_TAIL: begin
				if (tail_grow) begin
					if (!grow_over) begin
						len_we = 1'b1;
						len_wa = tail_q;
						len_wd = {1'b0, size_q};
						free_we = 1'b1;
						free_wa = tail_q;
					end
				end else if (!app_over && free_slot != NIL) begin
					start_we = 1'b1;
					start_wa = free_slot;
					start_wd = arena_q[19:0] + 20'(hdr_q);
					len_we = 1'b1;
					len_wa = free_slot;
					len_wd = {1'b0, size_q};
					free_we = 1'b1;
					free_wa = free_slot;
					succ_we = 1'b1;
					succ_wa = free_slot;
					succ_wd = NIL;
					pred_we = 1'b1;
					pred_wa = free_slot;
					pred_wd = tail_q;
				end
			end
			ffsca_pkg::ST_APPEND_LINK: begin
				succ_we = 1'b1;
				succ_wa = cur_q;
				succ_wd = slot_q;
			end
			ffsca_pkg::ST_REL_NEXT: begin
				rd_en = 1'b1;
				rd_idx = cur_pred_q;
				if (next_merge) begin
					len_we = 1'b1;
					len_wa = cur_q;
					len_wd = merge_next_len;
					succ_we = 1'b1;
					succ_wa = cur_q;
					succ_wd = rd_succ_q;
					pred_we = (rd_succ_q != NIL);
					pred_wa = rd_succ_q;
					pred_wd = cur_q;
				end
			end
			ffsca_pkg::ST_REL_PREV: begin
				if (prev_merge) begin
					len_we = 1'b1;
					len_wa = cur_pred_q;
					len_wd = merge_prev_len;
					succ_we = 1'b1;
					succ_wa = cur_pred_q;
					succ_wd = cur_succ_q;
					pred_we = (cur_succ_q != NIL);
					pred_wa = cur_succ_q;
					pred_wd = cur_pred_q;
				end
			end
			ffsca_pkg::ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (start_we) start_mem[start_wa[SLOT_W-1:0]] <= start_wd;
		if (len_we) len_mem[len_wa[SLOT_W-1:0]] <= len_wd;
		if (free_we) free_mem[free_wa[SLOT_W-1:0]] <= free_wd;
		if (succ_we) succ_mem[succ_wa[SLOT_W-1:0]] <= succ_wd;
		if (pred_we) pred_mem[pred_wa[SLOT_W-1:0]] <= pred_wd;
		if (rd_en) begin
			rd_start_q <= start_mem[rd_idx[SLOT_W-1:0]];
			rd_len_q <= len_mem[rd_idx[SLOT_W-1:0]];
			rd_free_q <= free_mem[rd_idx[SLOT_W-1:0]];
			rd_succ_q <= succ_mem[rd_idx[SLOT_W-1:0]];
			rd_pred_q <= pred_mem[rd_idx[SLOT_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffsca_pkg::ST_IDLE;
			hdr_q <= ffsca_pkg::HEADER_RESET;
			split_q <= ffsca_pkg::SPLIT_RESET;
			thr_q <= ffsca_pkg::THRESHOLD_RESET;
			in_use_q <= '0;
			head_q <= NIL;
			tail_q <= NIL;
			arena_q <= '0;
			fblk_q <= '0;
			blk_q <= '0;
			fbyte_q <= '0;
			byte_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				unique case (cfg_index)
					ffsca_pkg::CFG_HEADER_BYTES: hdr_q <= cfg_data[6:0];
					ffsca_pkg::CFG_SPLIT_MINIMUM: split_q <= cfg_data[11:0];
					ffsca_pkg::CFG_LARGE_THRESHOLD: thr_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (state_q == ffsca_pkg::ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ffsca_pkg::ST_FIT: begin
					if (split_ok) begin
						in_use_q[free_slot[SLOT_W-1:0]] <= 1'b1;
						if (rd_succ_q == NIL) tail_q <= free_slot;
						blk_q <= blk_q + 7'd1;
						byte_q <= byte_q - 21'(hdr_q);
						fbyte_q <= fbyte_q - {1'b0, size_q} - 21'(hdr_q);
					end else begin
						fblk_q <= fblk_q - 7'd1;
						fbyte_q <= fbyte_q - rd_len_q;
					end
				end
				ffsca_pkg::ST_TAIL: begin
					if (tail_grow) begin
						if (!grow_over) begin
							arena_q <= arena_q + grow_need;
							fblk_q <= fblk_q - 7'd1;
							fbyte_q <= fbyte_q - rd_len_q;
							byte_q <= byte_q + grow_need;
						end
					end else if (!app_over && free_slot != NIL) begin
						in_use_q[free_slot[SLOT_W-1:0]] <= 1'b1;
						if (tail_q == NIL) head_q <= free_slot;
						tail_q <= free_slot;
						arena_q <= arena_q + 21'(hdr_q) + {1'b0, size_q};
						blk_q <= blk_q + 7'd1;
						byte_q <= byte_q + {1'b0, size_q};
					end
				end
				ffsca_pkg::ST_WALK: begin
					if (op_q == ffsca_pkg::OP_RELEASE && cur_q != NIL &&
						rd_start_q == addr_q && !rd_free_q) begin
						fblk_q <= fblk_q + 7'd1;
						fbyte_q <= fbyte_q + rd_len_q;
					end
				end
				ffsca_pkg::ST_REL_NEXT: begin
					if (next_merge) begin
						if (rd_succ_q == NIL) tail_q <= cur_q;
						in_use_q[cur_succ_q[SLOT_W-1:0]] <= 1'b0;
						blk_q <= blk_q - 7'd1;
						byte_q <= byte_q + 21'(hdr_q);
						fblk_q <= fblk_q - 7'd1;
						fbyte_q <= fbyte_q + 21'(hdr_q);
					end
				end
				ffsca_pkg::ST_REL_PREV: begin
					if (prev_merge) begin
						if (cur_succ_q == NIL) tail_q <= cur_pred_q;
						in_use_q[cur_q[SLOT_W-1:0]] <= 1'b0;
						blk_q <= blk_q - 7'd1;
						byte_q <= byte_q + 21'(hdr_q);
						fblk_q <= fblk_q - 7'd1;
						fbyte_q <= fbyte_q + 21'(hdr_q);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ffsca_pkg::ST_IDLE: begin
				op_q <= s_tuser[0];
				size_q <= s_tdata[19:0];
				addr_q <= s_tdata[39:20];
				cur_q <= head_q;
				grant_q <= '0;
				status_q <= ffsca_pkg::STAT_OK;
				if (s_tuser[0] == ffsca_pkg::OP_ALLOCATE) begin
					if (s_tdata[19:0] == 20'd0) begin
						status_q <= ffsca_pkg::STAT_ZERO_SIZE;
					end else if ({1'b0, s_tdata[19:0]} >= thr_q) begin
						status_q <= ffsca_pkg::STAT_TOO_LARGE;
					end
				end
			end
			ffsca_pkg::ST_WALK: begin
				if (op_q == ffsca_pkg::OP_ALLOCATE) begin
					if (cur_q != NIL && !fits) cur_q <= rd_succ_q;
				end else if (cur_q == NIL) begin
					status_q <= ffsca_pkg::STAT_UNKNOWN;
				end else if (rd_start_q == addr_q) begin
					if (rd_free_q) status_q <= ffsca_pkg::STAT_UNKNOWN;
					cur_len_q <= rd_len_q;
					cur_succ_q <= rd_succ_q;
					cur_pred_q <= rd_pred_q;
				end else begin
					cur_q <= rd_succ_q;
				end
			end
			ffsca_pkg::ST_FIT: begin
				slot_q <= free_slot;
				grant_q <= rd_start_q;
			end
			ffsca_pkg::ST_TAIL: begin
				if (tail_grow) begin
					if (grow_over) status_q <= ffsca_pkg::STAT_FULL;
					else grant_q <= rd_start_q;
				end else if (app_over) begin
					status_q <= ffsca_pkg::STAT_FULL;
				end else if (free_slot == NIL) begin
					status_q <= ffsca_pkg::STAT_NO_SLOT;
				end else begin
					slot_q <= free_slot;
					cur_q <= tail_q;
					grant_q <= arena_q[19:0] + 20'(hdr_q);
				end
			end
			ffsca_pkg::ST_REL_NEXT: begin
				if (next_merge) begin
					cur_len_q <= merge_next_len;
					cur_succ_q <= rd_succ_q;
				end
			end
			ffsca_pkg::ST_DONE: begin
				if (out_free) begin
					m_tdata_q <= {1'b0, byte_q, blk_q, fbyte_q, fblk_q, grant_q, status_q};
				end
			end
			default: begin
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_list_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == NIL) == (tail_q == NIL))
		else $error("List head and tail disagree on an empty list.");

	a_free_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		fblk_q <= blk_q)
		else $error("More free blocks than blocks.");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("A second item was taken while one is in progress.");
`endif

endmodule
